/* rtl/assert_macros.svh */
// Assertion macros for the RTL file that carries checks (ppi_core).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define PPI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define PPI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/ppi_pkg.sv */
// ----------------------------------------------------------------------------
// ppi_pkg
// Types and constants of the parallel port block with keyboard code latch.
// ----------------------------------------------------------------------------
`default_nettype none

package ppi_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_KEY   = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ADDR_PORT_A  = 2'd0,
    ADDR_PORT_B  = 2'd1,
    ADDR_PORT_C  = 2'd2,
    ADDR_CONTROL = 2'd3
  } addr_e;

  // Direction bits and the mode-set bit of the control word.
  localparam int unsigned CW_PC_LO_IN = 0;
  localparam int unsigned CW_PB_IN    = 1;
  localparam int unsigned CW_PC_HI_IN = 3;
  localparam int unsigned CW_PA_IN    = 4;
  localparam int unsigned CW_MODE_SET = 7;

  localparam logic [7:0] CW_RESET       = 8'h9B;
  localparam logic [7:0] PA_DRIVEN_IDLE = 8'hFF;
  localparam logic [7:0] ALL_ONES       = 8'hFF;
  localparam logic [3:0] DIGIT_BLANK    = 4'hF;
  localparam logic [7:0] PC_KEY_MASK    = 8'hF1;
  localparam logic [7:0] PC_KEY_FLAG    = 8'h04;
  localparam logic [7:0] PC_PARITY_FLAG = 8'h02;

  typedef struct packed {
    cmd_e       command;
    addr_e      reg_addr;
    logic [7:0] data_in;
    logic       serial_in;
  } ppi_item_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] read_data;
    logic       irq_pending;
    logic [7:0] port_a_pins;
    logic [3:0] display_digit;
    logic       led_on;
  } ppi_result_t;

  function automatic logic [7:0] bit_reverse8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7 - i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/ppi_in_reg.sv */
// ----------------------------------------------------------------------------
// ppi_in_reg
// Input register: captures one command word per accepted start.
// ----------------------------------------------------------------------------
`default_nettype none

module ppi_in_reg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               take_i,
  input  wire ppi_pkg::ppi_item_t item_i,
  output logic                    valid_o,
  output ppi_pkg::ppi_item_t      item_o
);
  import ppi_pkg::*;

  logic      valid_q;
  ppi_item_t item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= take_i;
    end
  end

  // Payload needs no reset; it only matters while valid_q is set.
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

/* rtl/ppi_core.sv */
// ----------------------------------------------------------------------------
// ppi_core
// Port state, command decode and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ppi_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire ppi_pkg::ppi_item_t item_i,
  output ppi_pkg::ppi_result_t    res_o
);
  import ppi_pkg::*;

  logic [7:0] cw_q,   cw_d;
  logic [7:0] pa_q,   pa_d;
  logic [7:0] pb_q,   pb_d;
  logic [7:0] pc_q,   pc_d;
  logic [7:0] pbi_q,  pbi_d;
  logic [7:0] pci_q,  pci_d;
  logic       irq_q,  irq_d;
  logic [7:0] pad_q,  pad_d;
  logic [3:0] dig_q,  dig_d;
  logic       led_q,  led_d;
  logic [7:0] rd_q,   rd_d;
  logic       done_q;

  logic [7:0] rd_val;
  logic [2:0] bit_pos;
  logic [7:0] tick_pad;

  // Qualified command decodes used by the checks below.
  logic       key_take;
  logic       tick_take;
  logic       pa_float;

  // Value a bus read returns, chosen by the direction bits.
  always_comb begin
    rd_val = ALL_ONES;
    unique case (item_i.reg_addr)
      ADDR_PORT_A: rd_val = cw_q[CW_PA_IN] ? ALL_ONES : pa_q;
      ADDR_PORT_B: rd_val = cw_q[CW_PB_IN] ? pbi_q : pb_q;
      ADDR_PORT_C: begin
        rd_val[7:4] = cw_q[CW_PC_HI_IN] ? 4'hF : pc_q[7:4];
        rd_val[3:0] = cw_q[CW_PC_LO_IN] ? pci_q[3:0] : pc_q[3:0];
      end
      default: rd_val = ALL_ONES;
    endcase
  end

  assign bit_pos  = item_i.data_in[3:1];
  assign tick_pad = cw_q[CW_PA_IN] ? PA_DRIVEN_IDLE : pa_q;

  always_comb begin
    cw_d  = cw_q;
    pa_d  = pa_q;
    pb_d  = pb_q;
    pc_d  = pc_q;
    pbi_d = pbi_q;
    pci_d = pci_q;
    irq_d = irq_q;
    pad_d = pad_q;
    dig_d = dig_q;
    led_d = led_q;
    rd_d  = 8'h00;
    if (valid_i) begin
      unique case (item_i.command)
        CMD_WRITE: begin
          unique case (item_i.reg_addr)
            ADDR_PORT_A: pa_d = item_i.data_in;
            ADDR_PORT_B: pb_d = item_i.data_in;
            ADDR_PORT_C: pc_d = item_i.data_in;
            default: begin
              if (item_i.data_in[CW_MODE_SET]) begin
                cw_d = item_i.data_in;
              end else begin
                pc_d[bit_pos] = item_i.data_in[0];
              end
            end
          endcase
        end
        CMD_READ: rd_d = rd_val;
        CMD_KEY: begin
          irq_d = 1'b1;
          pbi_d = bit_reverse8(item_i.data_in);
          pci_d = (pci_q & PC_KEY_MASK) | PC_KEY_FLAG
                | ((^item_i.data_in) ? 8'h00 : PC_PARITY_FLAG);
        end
        default: begin
          pad_d    = tick_pad;
          dig_d    = cw_q[CW_PC_HI_IN] ? DIGIT_BLANK : pc_q[7:4];
          led_d    = tick_pad[4];
          pci_d[0] = tick_pad[3] ? 1'b1 : item_i.serial_in;
          if (!tick_pad[0]) begin
            irq_d = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q   <= CW_RESET;
      pa_q   <= 8'h00;
      pb_q   <= 8'h00;
      pc_q   <= 8'h00;
      pbi_q  <= 8'h00;
      pci_q  <= 8'h00;
      irq_q  <= 1'b0;
      pad_q  <= PA_DRIVEN_IDLE;
      dig_q  <= 4'h0;
      led_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cw_q   <= cw_d;
      pa_q   <= pa_d;
      pb_q   <= pb_d;
      pc_q   <= pc_d;
      pbi_q  <= pbi_d;
      pci_q  <= pci_d;
      irq_q  <= irq_d;
      pad_q  <= pad_d;
      dig_q  <= dig_d;
      led_q  <= led_d;
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= rd_d;
  end

  assign res_o.valid         = done_q;
  assign res_o.read_data     = rd_q;
  assign res_o.irq_pending   = irq_q;
  assign res_o.port_a_pins   = pad_q;
  assign res_o.display_digit = dig_q;
  assign res_o.led_on        = led_q;

  assign key_take  = valid_i && (item_i.command == CMD_KEY);
  assign tick_take = valid_i && (item_i.command == CMD_TICK);
  assign pa_float  = tick_take && cw_q[CW_PA_IN];

  `PPI_ASSERT(a_one_result, clk_i, rst_ni, valid_i |=> done_q, "item gave no result")
  `PPI_ASSERT(a_key_irq, clk_i, rst_ni, key_take |=> irq_q, "key code did not raise irq")
  `PPI_ASSERT(a_pa_float, clk_i, rst_ni, pa_float |=> (pad_q == PA_DRIVEN_IDLE), "port A not high")
  `PPI_ASSERT(a_led_follows, clk_i, rst_ni, tick_take |=> (led_q == pad_q[4]), "LED not port A bit 4")

endmodule

`default_nettype wire

/* rtl/ppi_port_block_with_keycode_latch.sv */
// ----------------------------------------------------------------------------
// ppi_port_block_with_keycode_latch
// Three-port parallel interface with a keyboard code latch.
// ----------------------------------------------------------------------------
// Usage:
//   An input word (command, register address, data byte, serial bit) is
//   accepted on a rising edge where start is high and busy is low. The block
//   takes a word in every cycle, so busy stays low at all times.
//   Each word produces exactly one result word. It passes the input register
//   and then the state and result registers, is shown on the result ports
//   marked by result_valid_o for a single cycle, and is taken at the rising
//   edge that ends that cycle. The receiver cannot hold results off, so
//   nothing in the block ever waits on it.
//   Throughput is one word per cycle: the input register feeds one shallow
//   pass of decode and port logic into the state and result registers, and
//   each word sees the state left by the word before it.
//   read_data_o carries the value of a bus read and zero for other commands.
//   irq_pending_o, port_a_pins_o, display_digit_o and led_on_o show the
//   port state after the word.
//   Reset loads control word 0x9B (all ports input), drives port A pins
//   high and clears every latch, the interrupt, the digit and the LED.
// ----------------------------------------------------------------------------
`default_nettype none

module ppi_port_block_with_keycode_latch (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] command_i,
  input  wire logic [1:0] reg_addr_i,
  input  wire logic [7:0] data_in_i,
  input  wire logic       serial_in_i,
  output logic            result_valid_o,
  output logic [7:0]      read_data_o,
  output logic            irq_pending_o,
  output logic [7:0]      port_a_pins_o,
  output logic [3:0]      display_digit_o,
  output logic            led_on_o
);
  import ppi_pkg::*;

  ppi_item_t   item_in;
  ppi_item_t   item_q;
  logic        item_valid;
  ppi_result_t res;
  logic        take;

  // The pipeline never stalls, so a word is taken whenever start is high.
  assign busy = 1'b0;
  assign take = start && !busy;

  // The command and address fields are 2-bit codes that span every value.
  assign item_in.command   = cmd_e'(command_i);
  assign item_in.reg_addr  = addr_e'(reg_addr_i);
  assign item_in.data_in   = data_in_i;
  assign item_in.serial_in = serial_in_i;

  ppi_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .item_i  (item_in),
    .valid_o (item_valid),
    .item_o  (item_q)
  );

  // All port state lives in the core; it updates once per word.
  ppi_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (item_valid),
    .item_i  (item_q),
    .res_o   (res)
  );

  assign result_valid_o  = res.valid;
  assign read_data_o     = res.read_data;
  assign irq_pending_o   = res.irq_pending;
  assign port_a_pins_o   = res.port_a_pins;
  assign display_digit_o = res.display_digit;
  assign led_on_o        = res.led_on;

endmodule

`default_nettype wire

/* verif/ppi_port_block_with_keycode_latch_checker.sv */
// ----------------------------------------------------------------------------
// ppi_port_block_with_keycode_latch_checker
// Watches the command and result channels of the parallel port block, keeps
// its own copy of the port state and compares every result word with the
// value that state predicts.
// ----------------------------------------------------------------------------
module ppi_port_block_with_keycode_latch_checker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic       busy_i,
  input  wire logic [1:0] command_i,
  input  wire logic [1:0] reg_addr_i,
  input  wire logic [7:0] data_in_i,
  input  wire logic       serial_in_i,
  input  wire logic       result_valid_i,
  input  wire logic [7:0] read_data_i,
  input  wire logic       irq_pending_i,
  input  wire logic [7:0] port_a_pins_i,
  input  wire logic [3:0] display_digit_i,
  input  wire logic       led_on_i,
  output int              errors_o,
  output int              pending_o,
  output int              checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ppi_pkg::*;

  // Shadow copy of the port state.
  logic [7:0] cw_shadow;
  logic [7:0] pa_latch;
  logic [7:0] pb_latch;
  logic [7:0] pc_latch;
  logic [7:0] pb_input;
  logic [7:0] pc_input;
  logic       irq_latch;
  logic [7:0] pa_driven;
  logic [3:0] digit;
  logic       led;

  ppi_result_t results_due[$];

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t ns: mismatch on %s, got 0x%02h, expected 0x%02h", $time, what, got, want);
    errors_o++;
  endtask

  // Applies one accepted word to the shadow state and returns the result word
  // that the block must produce for it.
  task automatic apply_port_word(input ppi_item_t w, output ppi_result_t r);
    logic [7:0] rd;
    logic [7:0] rev;
    rd = '0;
    case (w.command)
      CMD_WRITE: begin
        case (w.reg_addr)
          ADDR_PORT_A: pa_latch = w.data_in;
          ADDR_PORT_B: pb_latch = w.data_in;
          ADDR_PORT_C: pc_latch = w.data_in;
          default: begin
            if (w.data_in[CW_MODE_SET]) begin
              cw_shadow = w.data_in;
            end else begin
              pc_latch[w.data_in[3:1]] = w.data_in[0];
            end
          end
        endcase
      end
      CMD_READ: begin
        case (w.reg_addr)
          ADDR_PORT_A: rd = cw_shadow[CW_PA_IN] ? ALL_ONES : pa_latch;
          ADDR_PORT_B: rd = cw_shadow[CW_PB_IN] ? pb_input : pb_latch;
          ADDR_PORT_C: begin
            rd[7:4] = cw_shadow[CW_PC_HI_IN] ? 4'hF : pc_latch[7:4];
            rd[3:0] = cw_shadow[CW_PC_LO_IN] ? pc_input[3:0] : pc_latch[3:0];
          end
          default: rd = ALL_ONES;
        endcase
      end
      CMD_KEY: begin
        irq_latch = 1'b1;
        for (int i = 0; i < 8; i++) begin
          rev[i] = w.data_in[7 - i];
        end
        pb_input = rev;
        pc_input = (pc_input & PC_KEY_MASK) | PC_KEY_FLAG;
        // Even parity of the code raises the parity flag.
        if (!(^w.data_in)) begin
          pc_input = pc_input | PC_PARITY_FLAG;
        end
      end
      default: begin
        pa_driven = cw_shadow[CW_PA_IN] ? PA_DRIVEN_IDLE : pa_latch;
        digit = cw_shadow[CW_PC_HI_IN] ? DIGIT_BLANK : pc_latch[7:4];
        led = pa_driven[4];
        // Flash held in reset drives its serial output high.
        pc_input[0] = pa_driven[3] ? 1'b1 : w.serial_in;
        if (!pa_driven[0]) begin
          irq_latch = 1'b0;
        end
      end
    endcase
    r.valid = 1'b1;
    r.read_data = rd;
    r.irq_pending = irq_latch;
    r.port_a_pins = pa_driven;
    r.display_digit = digit;
    r.led_on = led;
  endtask

  initial begin
    errors_o = 0;
    pending_o = 0;
    checked_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    ppi_result_t want;
    ppi_result_t fresh;
    ppi_item_t   word;
    if (!rst_ni) begin
      cw_shadow = CW_RESET;
      pa_latch = '0;
      pb_latch = '0;
      pc_latch = '0;
      pb_input = '0;
      pc_input = '0;
      irq_latch = 1'b0;
      pa_driven = PA_DRIVEN_IDLE;
      digit = '0;
      led = 1'b0;
      results_due.delete();
    end else begin
      if (result_valid_i !== 1'b0) begin
        if (results_due.size() == 0) begin
          report_mismatch("result word with none pending", read_data_i, 8'h00);
        end else begin
          want = results_due.pop_front();
          checked_o++;
          if (read_data_i !== want.read_data) begin
            report_mismatch("read_data", read_data_i, want.read_data);
          end
          if (irq_pending_i !== want.irq_pending) begin
            report_mismatch("irq_pending", 8'(irq_pending_i), 8'(want.irq_pending));
          end
          if (port_a_pins_i !== want.port_a_pins) begin
            report_mismatch("port_a_pins", port_a_pins_i, want.port_a_pins);
          end
          if (display_digit_i !== want.display_digit) begin
            report_mismatch("display_digit", 8'(display_digit_i), 8'(want.display_digit));
          end
          if (led_on_i !== want.led_on) begin
            report_mismatch("led_on", 8'(led_on_i), 8'(want.led_on));
          end
        end
      end
      if (start_i && !busy_i) begin
        word.command = cmd_e'(command_i);
        word.reg_addr = addr_e'(reg_addr_i);
        word.data_in = data_in_i;
        word.serial_in = serial_in_i;
        apply_port_word(word, fresh);
        results_due.push_back(fresh);
      end
    end
    pending_o = results_due.size();
  end

endmodule

/* verif/ppi_port_block_with_keycode_latch_tb.sv */
// ----------------------------------------------------------------------------
// ppi_port_block_with_keycode_latch_tb
// Drives the parallel port block with directed and random bus writes, bus
// reads, keyboard codes and ticks under changing sender idle rates, while a
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module ppi_port_block_with_keycode_latch_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ppi_pkg::*;

  localparam int RANDOM_PER_PHASE = 250;
  localparam int DRAIN_CYCLES     = 6;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic [1:0] command_i;
  logic [1:0] reg_addr_i;
  logic [7:0] data_in_i;
  logic       serial_in_i;
  logic       result_valid_o;
  logic [7:0] read_data_o;
  logic       irq_pending_o;
  logic [7:0] port_a_pins_o;
  logic [3:0] display_digit_o;
  logic       led_on_o;

  int errors;
  int pending;
  int checked;

  // Percentage of cycles in which the sender holds start low before a word.
  int idle_pct;
  int words_sent;
  int directed_sent;

  ppi_port_block_with_keycode_latch dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .reg_addr_i     (reg_addr_i),
    .data_in_i      (data_in_i),
    .serial_in_i    (serial_in_i),
    .result_valid_o (result_valid_o),
    .read_data_o    (read_data_o),
    .irq_pending_o  (irq_pending_o),
    .port_a_pins_o  (port_a_pins_o),
    .display_digit_o(display_digit_o),
    .led_on_o       (led_on_o)
  );

  ppi_port_block_with_keycode_latch_checker port_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .command_i      (command_i),
    .reg_addr_i     (reg_addr_i),
    .data_in_i      (data_in_i),
    .serial_in_i    (serial_in_i),
    .result_valid_i (result_valid_o),
    .read_data_i    (read_data_o),
    .irq_pending_i  (irq_pending_o),
    .port_a_pins_i  (port_a_pins_o),
    .display_digit_i(display_digit_o),
    .led_on_i       (led_on_o),
    .errors_o       (errors),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard limit on the run. It lies far beyond the length of a correct run, so
  // it only fires when the block stops producing results or busy sticks high.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Sends one word. It is entered at a falling edge and returns at a falling
  // edge, so start is assigned only once per falling edge. Idle cycles come
  // first, then the word is held until a rising edge sees busy low.
  task automatic send_word(input cmd_e cmd, input addr_e addr, input logic [7:0] data,
                           input logic sin);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    command_i <= cmd;
    reg_addr_i <= addr;
    data_in_i <= data;
    serial_in_i <= sin;
    do begin
      @(posedge clk_i);
    end while (busy !== 1'b0);
    @(negedge clk_i);
    words_sent++;
  endtask

  initial begin
    int   pick;
    cmd_e cmd;
    // All inputs are known from time zero, while reset is held low at the start.
    rst_ni = 1'b0;
    start = 1'b0;
    command_i = CMD_READ;
    reg_addr_i = ADDR_PORT_A;
    data_in_i = '0;
    serial_in_i = 1'b0;
    idle_pct = 0;
    words_sent = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. After reset every port is an input: port A reads all
    // ones, port C upper reads all ones and the control address reads all
    // ones as well.
    send_word(CMD_READ, ADDR_PORT_A, 8'h00, 1'b0);
    send_word(CMD_READ, ADDR_PORT_B, 8'h00, 1'b0);
    send_word(CMD_READ, ADDR_PORT_C, 8'h00, 1'b0);
    send_word(CMD_READ, ADDR_CONTROL, 8'h00, 1'b0);
    // Port A floats high on a tick, so the flash is held in reset and the
    // serial bit is forced to one even though serial_in is low.
    send_word(CMD_TICK, ADDR_PORT_A, 8'h00, 1'b0);
    // Keyboard codes of even and odd parity, with the reversed code on port B.
    send_word(CMD_KEY, ADDR_PORT_A, 8'h00, 1'b0);
    send_word(CMD_READ, ADDR_PORT_C, 8'h00, 1'b0);
    send_word(CMD_KEY, ADDR_PORT_B, 8'hFF, 1'b1);
    send_word(CMD_KEY, ADDR_PORT_C, 8'h01, 1'b0);
    send_word(CMD_READ, ADDR_PORT_B, 8'h00, 1'b0);
    send_word(CMD_READ, ADDR_PORT_C, 8'h00, 1'b0);
    // Switch every port to output; the latches must keep their contents.
    send_word(CMD_WRITE, ADDR_CONTROL, 8'h80, 1'b0);
    send_word(CMD_WRITE, ADDR_PORT_A, 8'h00, 1'b0);
    send_word(CMD_WRITE, ADDR_PORT_B, 8'hFF, 1'b0);
    send_word(CMD_WRITE, ADDR_PORT_C, 8'hA5, 1'b0);
    // Bit set of port C bit 7, then bit reset of port C bit 4.
    send_word(CMD_WRITE, ADDR_CONTROL, 8'h0F, 1'b0);
    send_word(CMD_WRITE, ADDR_CONTROL, 8'h08, 1'b0);
    send_word(CMD_READ, ADDR_PORT_A, 8'h00, 1'b0);
    send_word(CMD_READ, ADDR_PORT_B, 8'h00, 1'b0);
    send_word(CMD_READ, ADDR_PORT_C, 8'h00, 1'b0);
    // Port A driven low: the interrupt is cleared, the serial bit is taken
    // from serial_in and the digit comes from the port C upper nibble.
    send_word(CMD_TICK, ADDR_PORT_B, 8'hFF, 1'b0);
    send_word(CMD_TICK, ADDR_PORT_C, 8'h00, 1'b1);
    send_word(CMD_WRITE, ADDR_PORT_A, 8'hFF, 1'b0);
    send_word(CMD_TICK, ADDR_CONTROL, 8'h00, 1'b0);
    send_word(CMD_WRITE, ADDR_CONTROL, CW_RESET, 1'b0);
    directed_sent = words_sent;

    // Random part in three idle mixes: light, heavy, none. Writes to the
    // control address carry random data, so about half of them load a new
    // control word and the rest set or clear a port C bit.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 10 : (phase == 1) ? 86 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        if (pick < 35) begin
          cmd = CMD_WRITE;
        end else if (pick < 65) begin
          cmd = CMD_READ;
        end else if (pick < 80) begin
          cmd = CMD_KEY;
        end else begin
          cmd = CMD_TICK;
        end
        send_word(cmd, addr_e'($urandom_range(3)), 8'($urandom_range(255)),
                  1'($urandom_range(1)));
      end
    end
    start <= 1'b0;

    // Drain: every result comes back through the input and result registers after
    // its word; the extra cycles catch any stray result strobe.
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Sent %0d words (%0d directed) under light, heavy and no sender idling.",
             words_sent, directed_sent);
    $display("Compared %0d result words field by field, %0d mismatches.", checked, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
